/* sv/fcss_pkg.sv */
// Shared types and constants for the fuel cell startup sequencer.
// Used by fcss_cfg, fcss_core and fuel_cell_startup_sequencer_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcss_pkg;

  // Width of the saturating millisecond timers.
  localparam int TIMER_BITS = 16;
  localparam int CFG_BITS   = 16;
  // Compare width wide enough for both timers and configured times.
  localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

  localparam int MODE_BITS  = 3;
  localparam int MV_BITS    = 16;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CMP_BITS-1:0]   cmp_t;
  typedef logic [CFG_BITS-1:0]   cfg_word_t;
  typedef logic [MV_BITS-1:0]    mv_t;

  // Event codes carried on the input beat; codes 6 and 7 are unused.
  typedef enum logic [MODE_BITS-1:0] {
    EV_TICK   = 3'd0,
    EV_BOARD  = 3'd1,
    EV_START  = 3'd2,
    EV_STOP   = 3'd3,
    EV_ACK    = 3'd4,
    EV_SAMPLE = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    PH_OFF     = 2'd0,
    PH_STARTUP = 2'd1,
    PH_CHARGE  = 2'd2,
    PH_RUN     = 2'd3
  } phase_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_PURGE       = 2'd2;
  localparam logic [1:0] REG_FULL_CHARGE = 2'd3;

  localparam cfg_word_t DEBOUNCE_RST    = 16'd1000;
  localparam cfg_word_t ACK_TIMEOUT_RST = 16'd5000;
  localparam cfg_word_t PURGE_RST       = 16'd500;
  localparam cfg_word_t FULL_CHARGE_RST = 16'd18000;

  typedef struct packed {
    cfg_word_t debounce_ms;
    cfg_word_t ack_timeout_ms;
    cfg_word_t purge_ms;
    cfg_word_t full_charge_mv;
  } cfg_t;

  typedef struct packed {
    logic   send_request;
    logic   purge_valve;
    logic   supply_valve;
    phase_t controller_state;
  } result_t;

endpackage

`default_nettype wire

/* sv/fcss_cfg.sv */
// Configuration register file behind the APB-style port.
// Depends on fcss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcss_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fcss_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [fcss_pkg::CFG_DW-1:0]  pwdata,
  output logic      [fcss_pkg::CFG_DW-1:0]  prdata,
  output fcss_pkg::cfg_t                    cfg
);
  import fcss_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;
  cfg_word_t  wdata;
  cfg_word_t  rdata;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign wdata   = pwdata[CFG_BITS-1:0];

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DEBOUNCE:    cfg_nxt.debounce_ms    = wdata;
        REG_ACK_TIMEOUT: cfg_nxt.ack_timeout_ms = wdata;
        REG_PURGE:       cfg_nxt.purge_ms       = wdata;
        REG_FULL_CHARGE: cfg_nxt.full_charge_mv = wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms    <= DEBOUNCE_RST;
      cfg_r.ack_timeout_ms <= ACK_TIMEOUT_RST;
      cfg_r.purge_ms       <= PURGE_RST;
      cfg_r.full_charge_mv <= FULL_CHARGE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register.
  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE:    rdata = cfg_r.debounce_ms;
      REG_ACK_TIMEOUT: rdata = cfg_r.ack_timeout_ms;
      REG_PURGE:       rdata = cfg_r.purge_ms;
      REG_FULL_CHARGE: rdata = cfg_r.full_charge_mv;
      default:         rdata = '0;
    endcase
  end

  assign prdata = CFG_DW'(rdata);
  assign cfg    = cfg_r;

endmodule

`default_nettype wire

/* sv/fcss_core.sv */
// Controller state and its one-event update; produces the result of each event.
// Depends on fcss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcss_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [fcss_pkg::MODE_BITS-1:0] mode,
  input  wire fcss_pkg::mv_t               cap_voltage_mv,
  input  wire fcss_pkg::cfg_t              cfg,
  output fcss_pkg::result_t                res
);
  import fcss_pkg::*;

  typedef struct packed {
    phase_t phase;
    logic   purging;
    timer_t phase_timer;
    timer_t since_press;
    logic   ack_pending;
    logic   supply_open;
    logic   purge_open;
  } st_t;

  localparam timer_t TMAX = '1;

  st_t  st_r;
  st_t  st_nxt;
  logic send;
  timer_t tick_timer;

  function automatic timer_t sat_inc(input timer_t v);
    return (v == TMAX) ? v : v + timer_t'(1);
  endfunction

  // Leaving to off keeps only the debounce count.
  function automatic st_t go_off(input st_t s);
    st_t o;
    o             = s;
    o.phase       = PH_OFF;
    o.purging     = 1'b0;
    o.ack_pending = 1'b0;
    o.supply_open = 1'b0;
    o.purge_open  = 1'b0;
    o.phase_timer = '0;
    return o;
  endfunction

  function automatic st_t go_startup(input st_t s);
    st_t o;
    o             = s;
    o.phase       = PH_STARTUP;
    o.purging     = 1'b0;
    o.ack_pending = 1'b1;
    o.supply_open = 1'b0;
    o.purge_open  = 1'b0;
    o.phase_timer = '0;
    return o;
  endfunction

  assign tick_timer = sat_inc(st_r.phase_timer);

  // Next state for the event in the input register.
  always_comb begin
    st_nxt = st_r;
    send   = 1'b0;
    unique case (mode)
      EV_TICK: begin
        st_nxt.since_press = sat_inc(st_r.since_press);
        if (st_r.phase == PH_STARTUP) begin
          st_nxt.phase_timer = tick_timer;
          if (st_r.ack_pending) begin
            if (cmp_t'(tick_timer) >= cmp_t'(cfg.ack_timeout_ms)) begin
              st_nxt = go_off(st_nxt);
            end
          end else if (st_r.purging) begin
            if (cmp_t'(tick_timer) >= cmp_t'(cfg.purge_ms)) begin
              st_nxt.purging     = 1'b0;
              st_nxt.purge_open  = 1'b0;
              st_nxt.phase       = PH_CHARGE;
              st_nxt.phase_timer = '0;
            end
          end
        end
      end
      EV_BOARD: begin
        if (cmp_t'(st_r.since_press) > cmp_t'(cfg.debounce_ms)) begin
          st_nxt.since_press = '0;
          if (st_r.phase != PH_OFF) begin
            st_nxt = go_off(st_nxt);
          end else begin
            st_nxt = go_startup(st_nxt);
            send   = 1'b1;
          end
        end
      end
      EV_START: begin
        if (st_r.phase != PH_OFF) begin
          st_nxt = go_off(st_r);
        end else begin
          st_nxt = go_startup(st_r);
          send   = 1'b1;
        end
      end
      EV_STOP: st_nxt = go_off(st_r);
      EV_ACK: begin
        if (st_r.phase == PH_STARTUP && st_r.ack_pending) begin
          st_nxt.ack_pending = 1'b0;
          st_nxt.purging     = 1'b1;
          st_nxt.supply_open = 1'b1;
          st_nxt.purge_open  = 1'b1;
          st_nxt.phase_timer = '0;
        end
      end
      EV_SAMPLE: begin
        if (st_r.phase == PH_CHARGE && cap_voltage_mv >= cfg.full_charge_mv) begin
          st_nxt.phase = PH_RUN;
        end
      end
      default: st_nxt = st_r;
    endcase
  end

  // State advances only when the event moves on to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= PH_OFF;
      st_r.purging     <= 1'b0;
      st_r.phase_timer <= '0;
      st_r.since_press <= '0;
      st_r.ack_pending <= 1'b0;
      st_r.supply_open <= 1'b0;
      st_r.purge_open  <= 1'b0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  assign res.controller_state = st_nxt.phase;
  assign res.supply_valve     = st_nxt.supply_open;
  assign res.purge_valve      = st_nxt.purge_open;
  assign res.send_request     = send;

endmodule

`default_nettype wire

/* sv/fuel_cell_startup_sequencer_top.sv */
// Top level of the fuel cell startup sequencer: input register, core, result register.
// Depends on fcss_pkg, fcss_cfg and fcss_core.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// in_       slave      tuser: mode[2:0]; tdata: cap_voltage_mv[15:0]
// out_      master     tdata: controller_state[1:0], supply_valve[2], purge_valve[3],
//                      send_request[4], zeros[7:5]
// cfg_      APB        four 16-bit registers at byte addresses 0, 4, 8, 12
//
// One event per clock sustained unless out_ stalls.
// The path is an input register, the one-step state update and a result register.
// Reset (synchronous, rst_n low) clears the controller and loads register defaults.
// A stall on out_ holds the result register; in_ keeps taking beats while the input
// register can move forward in the same cycle.

module fuel_cell_startup_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // cap_voltage_mv[15:0]
  input  wire logic [2:0]  in_tuser,   // mode[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // controller_state[1:0], supply_valve,
                                       // purge_valve, send_request, zero pad
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import fcss_pkg::*;

  cfg_t                 cfg;
  result_t              res;
  logic                 in_vld_r;
  logic [MODE_BITS-1:0] in_mode_r;
  mv_t                  in_mv_r;
  logic                 out_vld_r;
  result_t              out_res_r;
  logic                 step;

  assign cfg_pready = 1'b1;

  fcss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // The held event moves on when the result register is free or being emptied.
  assign step      = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | step;

  fcss_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .mode           (in_mode_r),
    .cap_voltage_mv (in_mv_r),
    .cfg            (cfg),
    .res            (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_mode_r <= in_tuser;
      in_mv_r   <= in_tdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_res_r.send_request, out_res_r.purge_valve,
                       out_res_r.supply_valve, out_res_r.controller_state};

endmodule

`default_nettype wire

/* verif/fcss_state_checker.sv */
// Checker for the fuel cell startup sequencer: watches the in_, out_ and cfg_ ports,
// predicts every result beat and compares it field by field. Depends on fcss_pkg.
`timescale 1ns / 1ps

module fcss_state_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [15:0] in_tdata,   // cap_voltage_mv[15:0]
  input  wire logic [2:0]  in_tuser,   // mode[2:0]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,  // controller_state[1:0], supply_valve,
                                       // purge_valve, send_request, zero pad
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               fail_count,
  output int               pending
);
  import fcss_pkg::*;

  // Shadow copy of the register file.
  cfg_word_t debounce_len;
  cfg_word_t ack_limit;
  cfg_word_t purge_len;
  cfg_word_t charge_mv;

  // Shadow copy of the controller.
  phase_t ctl_phase;
  logic   purge_active;
  logic   ack_wait;
  logic   supply_on;
  logic   purge_on;
  timer_t phase_ms;
  timer_t press_ms;

  result_t predicted_status[$];
  int      errs = 0;

  function automatic timer_t bump_ms(input timer_t v);
    return (v == '1) ? v : v + timer_t'(1);
  endfunction

  function automatic void shut_down();
    ctl_phase    = PH_OFF;
    purge_active = 1'b0;
    ack_wait     = 1'b0;
    supply_on    = 1'b0;
    purge_on     = 1'b0;
    phase_ms     = '0;
  endfunction

  // Off goes to startup and asks for the CAN message; any active phase goes off.
  function automatic logic toggle_power();
    if (ctl_phase != PH_OFF) begin
      shut_down();
      return 1'b0;
    end
    ctl_phase    = PH_STARTUP;
    purge_active = 1'b0;
    ack_wait     = 1'b1;
    supply_on    = 1'b0;
    purge_on     = 1'b0;
    phase_ms     = '0;
    return 1'b1;
  endfunction

  // Applies one event to the shadow controller and returns the status it reports.
  function automatic result_t step_sequencer(input logic [2:0] code, input mv_t mv);
    result_t r;
    logic    req;
    req = 1'b0;
    case (code)
      EV_TICK: begin
        press_ms = bump_ms(press_ms);
        if (ctl_phase == PH_STARTUP) begin
          phase_ms = bump_ms(phase_ms);
          if (ack_wait) begin
            if (phase_ms >= ack_limit) shut_down();
          end else if (purge_active) begin
            if (phase_ms >= purge_len) begin
              purge_active = 1'b0;
              purge_on     = 1'b0;
              ctl_phase    = PH_CHARGE;
              phase_ms     = '0;
            end
          end
        end
      end
      EV_BOARD: begin
        // A press inside the debounce window leaves the count running.
        if (press_ms > debounce_len) begin
          press_ms = '0;
          req      = toggle_power();
        end
      end
      EV_START: req = toggle_power();
      EV_STOP:  shut_down();
      EV_ACK: begin
        if (ctl_phase == PH_STARTUP && ack_wait) begin
          ack_wait     = 1'b0;
          purge_active = 1'b1;
          supply_on    = 1'b1;
          purge_on     = 1'b1;
          phase_ms     = '0;
        end
      end
      EV_SAMPLE: begin
        if (ctl_phase == PH_CHARGE && mv >= charge_mv) ctl_phase = PH_RUN;
      end
      default: ;
    endcase
    r.controller_state = ctl_phase;
    r.supply_valve     = supply_on;
    r.purge_valve      = purge_on;
    r.send_request     = req;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  // Sample every port at the clock edge, so all values are those before the edge.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      debounce_len = DEBOUNCE_RST;
      ack_limit    = ACK_TIMEOUT_RST;
      purge_len    = PURGE_RST;
      charge_mv    = FULL_CHARGE_RST;
      press_ms     = '0;
      shut_down();
      predicted_status.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_DEBOUNCE:    debounce_len = cfg_pwdata[15:0];
          REG_ACK_TIMEOUT: ack_limit    = cfg_pwdata[15:0];
          REG_PURGE:       purge_len    = cfg_pwdata[15:0];
          REG_FULL_CHARGE: charge_mv    = cfg_pwdata[15:0];
          default: ;
        endcase
      end

      // Result beat: compare against the oldest prediction.
      if (out_tvalid && out_tready) begin
        if (predicted_status.size() == 0) begin
          errs++;
          $display("%0t: result beat with nothing expected, actual 0x%02h", $time,
                   out_tdata);
        end else begin
          want = predicted_status.pop_front();
          check_field("controller_state", want.controller_state, out_tdata[1:0]);
          check_field("supply_valve", want.supply_valve, out_tdata[2]);
          check_field("purge_valve", want.purge_valve, out_tdata[3]);
          check_field("send_request", want.send_request, out_tdata[4]);
          check_field("pad bits", 0, out_tdata[7:5]);
        end
      end

      if (in_tvalid && in_tready) predicted_status.push_back(step_sequencer(in_tuser, in_tdata));
    end
    fail_count <= errs;
    pending    <= predicted_status.size();
  end

endmodule

/* verif/fuel_cell_startup_sequencer_top_tb.sv */
// Testbench top for the fuel cell startup sequencer: clock, reset, event stimulus,
// random back-pressure and register writes. Depends on fcss_pkg, the top level
// and fcss_state_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module fuel_cell_startup_sequencer_top_tb;
  import fcss_pkg::*;

  // Event codes the block does not define; it must report status unchanged.
  localparam logic [2:0] SPARE_MODE_LO = 3'd6;
  localparam logic [2:0] SPARE_MODE_HI = 3'd7;
  localparam int PHASE_ITEMS = 215;
  localparam int PHASES      = 8;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [15:0] in_tdata    = '0;
  logic [2:0]  in_tuser    = '0;
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending;

  // Register values now in force, used to shape the event sequences.
  cfg_word_t deb_now   = DEBOUNCE_RST;
  cfg_word_t ack_now   = ACK_TIMEOUT_RST;
  cfg_word_t purge_now = PURGE_RST;
  cfg_word_t fc_now    = FULL_CHARGE_RST;

  logic no_idle    = 1'b0;
  int   hold_cnt   = 0;
  int   items_sent = 0;

  always #5 clk = ~clk;

  fuel_cell_startup_sequencer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  fcss_state_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: stalls of random length between ready stretches of random length.
  always @(posedge clk) begin
    if (no_idle) begin
      out_tready <= 1'b1;
      hold_cnt   <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (out_tready && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= $urandom_range(1, 19) - 1;
    end else begin
      out_tready <= 1'b1;
      hold_cnt   <= $urandom_range(0, 40);
    end
  end

  task automatic pause_tx(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Holds off the input until every predicted result beat has been taken.
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Drives one event beat and returns at the edge that accepts it; tvalid stays high.
  task automatic send_event(input logic [2:0] code, input mv_t mv);
    if (!no_idle && $urandom_range(0, 9) == 0) pause_tx($urandom_range(1, 19));
    in_tuser  <= code;
    in_tdata  <= mv;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_event(EV_TICK, mv_t'($urandom));
  endtask

  // Setup cycle then access cycle; psel stays high into the next transfer.
  task automatic write_reg(input logic [1:0] idx, input cfg_word_t value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'h0000, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // Registers are only written with the block idle.
  task automatic apply_setting(input cfg_word_t deb, input cfg_word_t ack,
                               input cfg_word_t prg, input cfg_word_t fc);
    wait_results_done();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_ACK_TIMEOUT, ack);
    write_reg(REG_PURGE, prg);
    write_reg(REG_FULL_CHARGE, fc);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    deb_now   = deb;
    ack_now   = ack;
    purge_now = prg;
    fc_now    = fc;
  endtask

  // Voltages cluster around the charge threshold, with the field extremes mixed in.
  function automatic mv_t pick_voltage();
    case ($urandom_range(0, 5))
      0: return fc_now;
      1: return (fc_now == 16'h0000) ? fc_now : fc_now - mv_t'(1);
      2: return (fc_now == 16'hFFFF) ? fc_now : fc_now + mv_t'(1);
      3: return 16'h0000;
      4: return 16'hFFFF;
      default: return mv_t'($urandom);
    endcase
  endfunction

  // Occasional stray beat of any code, the unused ones included.
  task automatic maybe_noise();
    if ($urandom_range(0, 11) == 0) send_event(3'($urandom_range(0, 7)), mv_t'($urandom));
  endtask

  // One power-up attempt: start, acknowledge, purge, charge samples, then usually a stop or toggle.
  task automatic run_session();
    int n;
    int tail;
    if ($urandom_range(0, 9) < 6) begin
      send_event(EV_START, mv_t'($urandom));
    end else begin
      if ($urandom_range(0, 3) != 0) send_ticks((deb_now < 40) ? deb_now + 1 : 0);
      send_event(EV_BOARD, mv_t'($urandom));
    end
    maybe_noise();

    // Abort mid-startup now and then.
    if ($urandom_range(0, 9) == 0) begin
      send_event(($urandom_range(0, 1) != 0) ? EV_STOP : EV_START, mv_t'($urandom));
      return;
    end

    // Wait for the acknowledge; sometimes long enough to hit the timeout.
    n = (ack_now <= 40) ? $urandom_range(0, ack_now - 1) : $urandom_range(0, 40);
    if (ack_now <= 40 && $urandom_range(0, 4) == 0) n = int'(ack_now);
    send_ticks(n);
    if ($urandom_range(0, 9) != 0) send_event(EV_ACK, mv_t'($urandom));
    if ($urandom_range(0, 9) == 0) send_event(EV_ACK, mv_t'($urandom));
    maybe_noise();

    // Purge, ending anywhere near its configured length when that is at most 40.
    n = (purge_now <= 40) ? $urandom_range(purge_now - 1, purge_now + 3)
                          : $urandom_range(0, 40);
    send_ticks(n);
    maybe_noise();

    repeat ($urandom_range(1, 4)) begin
      send_event(EV_SAMPLE, pick_voltage());
      if ($urandom_range(0, 2) == 0) send_ticks($urandom_range(1, 3));
    end
    maybe_noise();

    tail = $urandom_range(0, 19);
    if (tail < 9) send_event(EV_STOP, mv_t'($urandom));
    else if (tail < 13) send_event(EV_START, mv_t'($urandom));
    else if (tail < 16) send_event(EV_BOARD, mv_t'($urandom));
    if (!no_idle && $urandom_range(0, 49) == 0) wait_results_done();
  endtask

  initial begin
    int base;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events under the reset register values.
    send_event(EV_STOP, 16'h0000);        // stop while off
    send_event(EV_ACK, 16'h0000);         // acknowledge outside startup
    send_event(EV_SAMPLE, 16'hFFFF);      // sample outside charge
    send_event(SPARE_MODE_LO, 16'h0000);
    send_event(SPARE_MODE_HI, 16'hFFFF);
    send_event(EV_BOARD, 16'h0000);       // inside the debounce window
    send_event(EV_START, 16'h0000);
    send_event(EV_TICK, 16'h0000);
    send_event(EV_START, 16'h0000);       // toggle off mid-startup
    send_event(EV_START, 16'h0000);
    send_event(EV_STOP, 16'h0000);        // stop aborts startup
    send_event(EV_START, 16'h0000);
    send_event(EV_ACK, 16'h0000);
    send_event(EV_ACK, 16'hFFFF);         // second acknowledge is ignored
    send_event(EV_SAMPLE, 16'h0000);
    send_event(EV_STOP, 16'h0000);

    // Shortest times and the top threshold: timeout, purge end, run, debounce.
    apply_setting(16'd0, 16'd1, 16'd1, 16'hFFFF);
    send_event(EV_BOARD, 16'h0000);
    send_event(EV_TICK, 16'h0000);        // acknowledge timeout
    send_event(EV_START, 16'h0000);
    send_event(EV_ACK, 16'h0000);
    send_event(EV_TICK, 16'h0000);        // purge ends, charge
    send_event(EV_SAMPLE, 16'hFFFE);
    send_event(EV_SAMPLE, 16'hFFFF);      // run
    send_event(EV_BOARD, 16'h0000);
    send_event(EV_BOARD, 16'h0000);       // rejected, count just restarted

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_setting(16'd0, 16'd1, 16'd1, 16'd0);
        1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: apply_setting(cfg_word_t'($urandom_range(0, 25)),
                               cfg_word_t'($urandom_range(1, 30)),
                               cfg_word_t'($urandom_range(1, 30)),
                               cfg_word_t'($urandom));
      endcase
      if (p == PHASES - 1) no_idle = 1'b1;
      base = items_sent;
      while (items_sent - base < PHASE_ITEMS) run_session();
    end

    wait_results_done();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("fuel_cell_startup_sequencer_top regression: pass");
    end else begin
      $display("fuel_cell_startup_sequencer_top regression: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("fuel_cell_startup_sequencer_top regression: fail");
    $finish;
  end

endmodule
